### rtl/rbmi_pkg.sv
package rbmi_pkg;

    // Word formats
    localparam int W         = 32;
    localparam int INV_W     = 31;
    localparam int TIME_BITS = 16;

    // Shared multiplier operands and product
    localparam int A_W    = W + 1;
    localparam int B_W    = W;
    localparam int PROD_W = A_W + B_W;
    localparam int ACC_W  = PROD_W + 1;

    // inv * t and its split for the half term, floor(inv * t * t / 2^(2*TIME_BITS+1))
    localparam int P_W    = INV_W + TIME_BITS;
    localparam int LO_W   = TIME_BITS + 1;
    localparam int HALF_W = P_W + TIME_BITS - (2 * TIME_BITS + 1);

    // Commands
    localparam logic [2:0] CMD_TICK       = 3'd0;
    localparam logic [2:0] CMD_ADD_FORCE  = 3'd1;
    localparam logic [2:0] CMD_TORQUE_PT  = 3'd2;
    localparam logic [2:0] CMD_FORCE_PT   = 3'd3;
    localparam logic [2:0] CMD_ADD_VEL    = 3'd4;
    localparam logic [2:0] CMD_ADD_ANGVEL = 3'd5;
    localparam logic [2:0] CMD_STOP       = 3'd6;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_MOMENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COG_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COG_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COG_Z      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR      = 3'd5;

    // State word kinds within one body (linear or angular)
    localparam logic [1:0] K_POS = 2'd0;
    localparam logic [1:0] K_VEL = 2'd1;
    localparam logic [1:0] K_ACC = 2'd2;

    // Multiplier operand A select
    localparam logic [2:0] A_VEL  = 3'd0;
    localparam logic [2:0] A_FRC  = 3'd1;
    localparam logic [2:0] A_INV  = 3'd2;
    localparam logic [2:0] A_PHI  = 3'd3;
    localparam logic [2:0] A_PLO  = 3'd4;
    localparam logic [2:0] A_VEC  = 3'd5;
    localparam logic [2:0] A_DIFF = 3'd6;

    // Multiplier operand B select
    localparam logic [2:0] B_T    = 3'd0;
    localparam logic [2:0] B_HALF = 3'd1;
    localparam logic [2:0] B_LIN  = 3'd2;
    localparam logic [2:0] B_ONE  = 3'd3;
    localparam logic [2:0] B_VEC  = 3'd4;

    // Product shift
    localparam logic [1:0] SH_ZERO  = 2'd0;
    localparam logic [1:0] SH_TIME  = 2'd1;
    localparam logic [1:0] SH_TIME1 = 2'd2;
    localparam logic [1:0] SH_FRAC  = 2'd3;

    // Addend of the shifted product
    localparam logic [1:0] BASE_ZERO  = 2'd0;
    localparam logic [1:0] BASE_ACC   = 2'd1;
    localparam logic [1:0] BASE_STATE = 2'd2;

    // Destination of the sum
    localparam logic [2:0] DST_NONE  = 3'd0;
    localparam logic [2:0] DST_P     = 3'd1;
    localparam logic [2:0] DST_HALF  = 3'd2;
    localparam logic [2:0] DST_ACC   = 3'd3;
    localparam logic [2:0] DST_STATE = 3'd4;

    // Microprogram step layout
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] TICK_BODY_LEN = 5'd13;
    localparam logic [STEP_W-1:0] TICK_LAST     = 5'd25;
    localparam logic [STEP_W-1:0] VEC_LAST      = 5'd2;
    localparam logic [STEP_W-1:0] FPT_LAST      = 5'd5;
    localparam logic [3:0] TS_INV_T = 4'd0;
    localparam logic [3:0] TS_LO    = 4'd2;
    localparam logic [3:0] TS_HI    = 4'd3;
    localparam logic [3:0] TS_AXIS  = 4'd4;
    localparam logic [3:0] TS_VEL   = 4'd10;

    typedef struct packed {
        logic       valid;
        logic [1:0] shift;
        logic [1:0] base;
        logic [2:0] dst;
        logic       body;
        logic [1:0] kind;
        logic [1:0] axis;
    } t_alu_ctl;

    typedef struct packed {
        t_alu_ctl   alu;
        logic [2:0] a_sel;
        logic [2:0] b_sel;
        logic       last;
    } t_uop;

    // Microprogram: at most one multiply-accumulate per step
    function automatic t_uop uop_rom(input logic [2:0] cmd, input logic [STEP_W-1:0] step);
        t_uop       u;
        logic       body;
        logic [3:0] s;
        u = '0;
        u.alu.dst = DST_NONE;
        body = (step >= TICK_BODY_LEN);
        s = body ? 4'(step - TICK_BODY_LEN) : step[3:0];
        case (cmd)
            CMD_TICK: begin
                u.alu.body = body;
                u.last = (step == TICK_LAST);
                if (s == TS_INV_T) begin
                    u.alu.valid = 1'b1;
                    u.a_sel = A_INV;
                    u.b_sel = B_T;
                    u.alu.shift = SH_ZERO;
                    u.alu.base = BASE_ZERO;
                    u.alu.dst = DST_P;
                end else if (s == TS_LO) begin
                    u.alu.valid = 1'b1;
                    u.a_sel = A_PLO;
                    u.b_sel = B_T;
                    u.alu.shift = SH_TIME1;
                    u.alu.base = BASE_ZERO;
                    u.alu.dst = DST_ACC;
                end else if (s == TS_HI) begin
                    u.alu.valid = 1'b1;
                    u.a_sel = A_PHI;
                    u.b_sel = B_T;
                    u.alu.shift = SH_ZERO;
                    u.alu.base = BASE_ACC;
                    u.alu.dst = DST_HALF;
                end else if (s >= TS_AXIS && s < TS_VEL) begin
                    u.alu.valid = 1'b1;
                    u.alu.kind = K_POS;
                    u.alu.axis = 2'((s - TS_AXIS) >> 1);
                    if (!s[0]) begin
                        // v * t plus the old position
                        u.a_sel = A_VEL;
                        u.b_sel = B_T;
                        u.alu.shift = SH_TIME;
                        u.alu.base = BASE_STATE;
                        u.alu.dst = DST_ACC;
                    end else begin
                        // F * half, then store the position
                        u.a_sel = A_FRC;
                        u.b_sel = B_HALF;
                        u.alu.shift = SH_FRAC;
                        u.alu.base = BASE_ACC;
                        u.alu.dst = DST_STATE;
                    end
                end else if (s >= TS_VEL) begin
                    u.alu.valid = 1'b1;
                    u.alu.kind = K_VEL;
                    u.alu.axis = 2'(s - TS_VEL);
                    u.a_sel = A_FRC;
                    u.b_sel = B_LIN;
                    u.alu.shift = SH_FRAC;
                    u.alu.base = BASE_STATE;
                    u.alu.dst = DST_STATE;
                end
            end
            CMD_ADD_FORCE, CMD_ADD_VEL, CMD_ADD_ANGVEL: begin
                u.alu.valid = 1'b1;
                u.alu.body = (cmd == CMD_ADD_ANGVEL);
                u.alu.kind = (cmd == CMD_ADD_FORCE) ? K_ACC : K_VEL;
                u.alu.axis = step[1:0];
                u.a_sel = A_VEC;
                u.b_sel = B_ONE;
                u.alu.shift = SH_ZERO;
                u.alu.base = BASE_STATE;
                u.alu.dst = DST_STATE;
                u.last = (step == VEC_LAST);
            end
            CMD_TORQUE_PT, CMD_FORCE_PT: begin
                u.alu.valid = 1'b1;
                u.alu.kind = K_ACC;
                u.alu.base = BASE_STATE;
                u.alu.dst = DST_STATE;
                if (cmd == CMD_FORCE_PT && step <= VEC_LAST) begin
                    u.alu.body = 1'b0;
                    u.alu.axis = step[1:0];
                    u.a_sel = A_VEC;
                    u.b_sel = B_ONE;
                    u.alu.shift = SH_ZERO;
                end else begin
                    u.alu.body = 1'b1;
                    u.alu.axis = (cmd == CMD_FORCE_PT) ? 2'(step - VEC_LAST - 5'd1)
                                                       : step[1:0];
                    u.a_sel = A_DIFF;
                    u.b_sel = B_VEC;
                    u.alu.shift = SH_FRAC;
                end
                u.last = (cmd == CMD_FORCE_PT) ? (step == FPT_LAST) : (step == VEC_LAST);
            end
            default: begin
                u.last = 1'b1;
            end
        endcase
        return u;
    endfunction

endpackage

### rtl/rbmi_mul.sv
module rbmi_mul import rbmi_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [A_W-1:0]    i_a,
    input  logic signed [B_W-1:0]    i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // Register the full signed product
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

### rtl/rbmi_alu.sv
module rbmi_alu import rbmi_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  t_alu_ctl                 i_ctl,
    input  logic signed [PROD_W-1:0] i_prod,
    input  logic signed [W-1:0]      i_base,
    output logic signed [ACC_W-1:0]  o_sum,
    output logic signed [W-1:0]      o_sat,
    output logic                     o_clip
);

    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] w_prod_ext;
    logic signed [ACC_W-1:0] w_shifted;
    logic signed [ACC_W-1:0] w_base;
    logic signed [ACC_W-1:0] w_sum;
    logic                    w_ovf;

    assign w_prod_ext = {i_prod[PROD_W-1], i_prod};

    // Scale the product, rounding toward minus infinity
    always_comb begin
        case (i_ctl.shift)
            SH_ZERO:  w_shifted = w_prod_ext;
            SH_TIME:  w_shifted = w_prod_ext >>> TIME_BITS;
            SH_TIME1: w_shifted = w_prod_ext >>> (TIME_BITS + 1);
            SH_FRAC:  w_shifted = w_prod_ext >>> FRAC_BITS;
            default:  w_shifted = w_prod_ext;
        endcase
    end

    // Pick the addend
    always_comb begin
        case (i_ctl.base)
            BASE_ZERO:  w_base = '0;
            BASE_ACC:   w_base = r_acc;
            BASE_STATE: w_base = {{(ACC_W - W){i_base[W-1]}}, i_base};
            default:    w_base = '0;
        endcase
    end

    assign w_sum = w_base + w_shifted;

    // Clip to the signed word range
    assign w_ovf  = !((&w_sum[ACC_W-1:W-1]) || !(|w_sum[ACC_W-1:W-1]));
    assign o_sat  = w_ovf ? (w_sum[ACC_W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
                          : w_sum[W-1:0];
    assign o_clip = i_ctl.valid && (i_ctl.dst == DST_STATE) && w_ovf;
    assign o_sum  = w_sum;

    // Hold the running sum between steps
    always_ff @(posedge i_clk) begin
        if (i_ctl.valid && i_ctl.dst == DST_ACC) begin
            r_acc <= w_sum;
        end
    end

endmodule

### rtl/rigid_body_motion_integrator_core.sv
// Rigid body motion integrator: position, rotation, velocity, force, angular
// velocity and torque of one body in signed fixed point.
// Input channel: i_valid / o_stall with i_command and its operands; a
// transaction is taken when i_valid is high and o_stall is low. Output
// channel: o_valid / i_stall with the pose after the item, floor_hit and
// saturated; one result per input transaction.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// o_cfg_ready is always high. Write only while the block is idle.
// Timing: every product goes through one shared 33x32 multiplier, one per
// cycle, followed by one add and clip stage. A tick issues 26 multiplier
// steps. The result is registered and shows in the same cycle as the block
// can take the next transaction.
// o_stall is high from acceptance until the result is loaded. While the
// receiver stalls, the result holds and a finished item waits in its last
// state before loading the next result.
// Reset (synchronous, active low) clears all motion state, loads inverse
// mass and moment of one, centre of gravity zero and floor at minus three.
module rigid_body_motion_integrator_core import rbmi_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [2:0]           i_command,
    input  logic signed [W-1:0]  i_vec_x,
    input  logic signed [W-1:0]  i_vec_y,
    input  logic signed [W-1:0]  i_vec_z,
    input  logic signed [W-1:0]  i_point_x,
    input  logic signed [W-1:0]  i_point_y,
    input  logic signed [W-1:0]  i_point_z,
    input  logic [TIME_BITS-1:0] i_time_step,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [W-1:0]  o_pos_x,
    output logic signed [W-1:0]  o_pos_y,
    output logic signed [W-1:0]  o_pos_z,
    output logic signed [W-1:0]  o_rot_x,
    output logic signed [W-1:0]  o_rot_y,
    output logic signed [W-1:0]  o_rot_z,
    output logic                 o_floor_hit,
    output logic                 o_saturated,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [W-1:0]         i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    localparam logic [INV_W-1:0] INV_RST   = INV_W'(1 << FRAC_BITS);
    localparam int               FLOOR_INT = -3 * (1 << FRAC_BITS);
    localparam logic [W-1:0]     FLOOR_RST = W'(FLOOR_INT);

    // Sequencer
    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [STEP_W-1:0] r_step;
    t_alu_ctl          r_ctl;
    t_uop              w_uop;

    // Captured transaction
    logic [2:0]           r_cmd;
    logic signed [W-1:0]  r_vec [3];
    logic signed [W-1:0]  r_pt [3];
    logic [TIME_BITS-1:0] r_t;
    logic signed [A_W-1:0] r_diff [3];

    // Body state: [linear/angular][pos/vel/acc][axis]
    logic signed [W-1:0] r_st [2][3][3];

    // Configuration
    logic [INV_W-1:0]    r_inv_mass;
    logic [INV_W-1:0]    r_inv_moment;
    logic signed [W-1:0] r_cog [3];
    logic signed [W-1:0] r_floor;

    // Per-body intermediates
    logic [P_W-1:0]    r_p;
    logic [HALF_W-1:0] r_half;

    // Flags and result register
    logic                r_hit;
    logic                r_clip;
    logic                r_out_valid;
    logic signed [W-1:0] r_pos [3];
    logic signed [W-1:0] r_rot [3];
    logic                r_out_hit;
    logic                r_out_sat;

    logic                     w_in_acc;
    logic                     w_floor_le;
    logic                     w_clear;
    logic                     w_out_load;
    logic signed [A_W-1:0]    w_a;
    logic signed [B_W-1:0]    w_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [W-1:0]      w_base;
    logic signed [ACC_W-1:0]  w_sum;
    logic signed [W-1:0]      w_sat;
    logic                     w_clip;
    logic signed [W-1:0]      w_opv;
    logic signed [W-1:0]      w_opf;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid && !o_stall;
    assign w_floor_le  = (r_st[0][K_POS][1] <= r_floor);
    assign w_clear     = (r_state == S_PREP)
                       && ((r_cmd == CMD_TICK && w_floor_le) || r_cmd == CMD_STOP);
    assign w_out_load  = (r_state == S_FIN) && (!r_out_valid || !i_stall);

    assign w_uop = uop_rom(r_cmd, r_step);

    // Next sequencer state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_PREP;
            end
            S_PREP: begin
                if (r_cmd == CMD_STOP || r_cmd > CMD_ADD_ANGVEL) n_state = S_FIN;
                else n_state = S_RUN;
            end
            S_RUN: begin
                if (w_uop.last) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_FIN;
            S_FIN: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Advance the sequencer and issue one step per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_ctl   <= '0;
        end else begin
            r_state <= n_state;
            r_ctl   <= (r_state == S_RUN) ? w_uop.alu : '0;
            if (r_state == S_RUN) r_step <= r_step + 1'b1;
            else r_step <= '0;
        end
    end

    // Multiplier operands
    assign w_opv = r_st[w_uop.alu.body][K_VEL][w_uop.alu.axis];
    assign w_opf = r_st[w_uop.alu.body][K_ACC][w_uop.alu.axis];

    always_comb begin
        case (w_uop.a_sel)
            A_VEL:   w_a = {w_opv[W-1], w_opv};
            A_FRC:   w_a = {w_opf[W-1], w_opf};
            A_INV:   w_a = w_uop.alu.body ? {{(A_W - INV_W){1'b0}}, r_inv_moment}
                                          : {{(A_W - INV_W){1'b0}}, r_inv_mass};
            A_PHI:   w_a = {{(A_W - (P_W - LO_W)){1'b0}}, r_p[P_W-1:LO_W]};
            A_PLO:   w_a = {{(A_W - LO_W){1'b0}}, r_p[LO_W-1:0]};
            A_VEC:   w_a = {r_vec[w_uop.alu.axis][W-1], r_vec[w_uop.alu.axis]};
            A_DIFF:  w_a = r_diff[w_uop.alu.axis];
            default: w_a = '0;
        endcase
    end

    always_comb begin
        case (w_uop.b_sel)
            B_T:     w_b = {{(B_W - TIME_BITS){1'b0}}, r_t};
            B_HALF:  w_b = {{(B_W - HALF_W){1'b0}}, r_half};
            B_LIN:   w_b = {{(B_W - (P_W - TIME_BITS)){1'b0}}, r_p[P_W-1:TIME_BITS]};
            B_ONE:   w_b = {{(B_W - 1){1'b0}}, 1'b1};
            B_VEC:   w_b = r_vec[w_uop.alu.axis];
            default: w_b = '0;
        endcase
    end

    rbmi_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    assign w_base = r_st[r_ctl.body][r_ctl.kind][r_ctl.axis];

    rbmi_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .i_clk  (i_clk),
        .i_ctl  (r_ctl),
        .i_prod (w_prod),
        .i_base (w_base),
        .o_sum  (w_sum),
        .o_sat  (w_sat),
        .o_clip (w_clip)
    );

    // Body state, configuration and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < 2; b++) begin
                for (int k = 0; k < 3; k++) begin
                    for (int i = 0; i < 3; i++) begin
                        r_st[b][k][i] <= '0;
                    end
                end
            end
            r_inv_mass   <= INV_RST;
            r_inv_moment <= INV_RST;
            for (int i = 0; i < 3; i++) begin
                r_cog[i] <= '0;
            end
            r_floor <= FLOOR_RST;
            r_hit   <= 1'b0;
            r_clip  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_INV_MASS:   r_inv_mass   <= i_cfg_data[INV_W-1:0];
                    CFG_INV_MOMENT: r_inv_moment <= i_cfg_data[INV_W-1:0];
                    CFG_COG_X:      r_cog[0]     <= i_cfg_data;
                    CFG_COG_Y:      r_cog[1]     <= i_cfg_data;
                    CFG_COG_Z:      r_cog[2]     <= i_cfg_data;
                    CFG_FLOOR:      r_floor      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                r_hit  <= 1'b0;
                r_clip <= 1'b0;
            end
            // Drop all motion on a floor contact or a stop
            if (w_clear) begin
                r_hit <= (r_cmd == CMD_TICK);
                for (int b = 0; b < 2; b++) begin
                    for (int i = 0; i < 3; i++) begin
                        r_st[b][K_VEL][i] <= '0;
                        r_st[b][K_ACC][i] <= '0;
                    end
                end
            end
            // Write back one step
            if (r_ctl.valid && r_ctl.dst == DST_STATE) begin
                r_st[r_ctl.body][r_ctl.kind][r_ctl.axis] <= w_sat;
            end
            if (w_clip) r_clip <= 1'b1;
        end
    end

    // Transaction capture and per-body intermediates
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd    <= i_command;
            r_vec[0] <= i_vec_x;
            r_vec[1] <= i_vec_y;
            r_vec[2] <= i_vec_z;
            r_pt[0]  <= i_point_x;
            r_pt[1]  <= i_point_y;
            r_pt[2]  <= i_point_z;
            r_t      <= i_time_step;
        end
        if (r_state == S_PREP) begin
            for (int i = 0; i < 3; i++) begin
                r_diff[i] <= {r_pt[i][W-1], r_pt[i]} - {r_cog[i][W-1], r_cog[i]};
            end
        end
        if (r_ctl.valid && r_ctl.dst == DST_P) r_p <= w_sum[P_W-1:0];
        if (r_ctl.valid && r_ctl.dst == DST_HALF) r_half <= w_sum[TIME_BITS +: HALF_W];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= r_st[0][K_POS][i];
                r_rot[i] <= r_st[1][K_POS][i];
            end
            r_out_hit <= r_hit;
            r_out_sat <= r_clip;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pos_x     = r_pos[0];
    assign o_pos_y     = r_pos[1];
    assign o_pos_z     = r_pos[2];
    assign o_rot_x     = r_rot[0];
    assign o_rot_y     = r_rot[1];
    assign o_rot_z     = r_rot[2];
    assign o_floor_hit = r_out_hit;
    assign o_saturated = r_out_sat;

`ifndef SYNTH
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_FIN))
        else $error("result appeared outside the finish state");

    a_step_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.valid |-> (r_state == S_RUN || r_state == S_DRAIN))
        else $error("arithmetic step active outside the run");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_step <= TICK_LAST))
        else $error("step counter ran past the microprogram");

    a_clear_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> (r_st[0][K_VEL][1] == '0 && r_st[1][K_ACC][2] == '0))
        else $error("motion terms not cleared");
`endif

endmodule
